// ----- design/ltms_pkg.sv -----
// Package for the loser tree merge selector: request codes, microcode format and control ROM.
`timescale 1ns / 1ps

package ltms_pkg;

   // Request codes.
   localparam int REQ_BITS = 2;
   localparam logic [REQ_BITS-1:0] REQ_LOAD    = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_BUILD   = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_REPLACE = 2'd2;

   // Leaf count register.
   localparam int CSR_BITS = 5;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 5'd16;

   // Microprogram addresses.
   localparam int UPC_BITS = 4;
   localparam logic [UPC_BITS-1:0] U_B_START = 4'd0;
   localparam logic [UPC_BITS-1:0] U_B_LOOP  = 4'd1;
   localparam logic [UPC_BITS-1:0] U_B_RD1   = 4'd2;
   localparam logic [UPC_BITS-1:0] U_B_PAIR  = 4'd3;
   localparam logic [UPC_BITS-1:0] U_B_CHK   = 4'd4;
   localparam logic [UPC_BITS-1:0] U_B_EMP   = 4'd5;
   localparam logic [UPC_BITS-1:0] U_B_CMP   = 4'd6;
   localparam logic [UPC_BITS-1:0] U_R_CHK   = 4'd7;
   localparam logic [UPC_BITS-1:0] U_R_EMP   = 4'd8;
   localparam logic [UPC_BITS-1:0] U_R_CMP   = 4'd9;
   localparam logic [UPC_BITS-1:0] U_FIN     = 4'd10;
   localparam logic [UPC_BITS-1:0] U_REPORT  = 4'd11;

   // Jump conditions.
   localparam int COND_BITS = 3;
   localparam logic [COND_BITS-1:0] COND_NONE       = 3'd0;
   localparam logic [COND_BITS-1:0] COND_ALWAYS     = 3'd1;
   localparam logic [COND_BITS-1:0] COND_J_DONE     = 3'd2;
   localparam logic [COND_BITS-1:0] COND_K_ZERO     = 3'd3;
   localparam logic [COND_BITS-1:0] COND_NODE_EMPTY = 3'd4;
   localparam logic [COND_BITS-1:0] COND_RSP_BUSY   = 3'd5;

   // When the operations of a word take effect.
   localparam logic [1:0] EX_ALWAYS    = 2'd0;
   localparam logic [1:0] EX_TAKEN     = 2'd1;
   localparam logic [1:0] EX_NOT_TAKEN = 2'd2;

   // Key memory read address select.
   localparam logic [1:0] RS_I    = 2'd0;
   localparam logic [1:0] RS_I1   = 2'd1;
   localparam logic [1:0] RS_NODE = 2'd2;
   localparam logic [1:0] RS_CUR  = 2'd3;

   typedef struct packed {
      logic clr_valid;
      logic init_build;
      logic save_a;
      logic pair;
      logic set_cur;
      logic fill;
      logic climb;
      logic halve;
      logic report;
   } ops_type;

   typedef struct packed {
      logic [COND_BITS-1:0] cond;
      logic [UPC_BITS-1:0]  target;
      logic [1:0]           exec;
      logic [1:0]           rsel;
      logic                 fin;
      ops_type              ops;
   } ucode_type;

   // Control store: one word per step of the build and replace programs.
   function automatic ucode_type rom_word(input logic [UPC_BITS-1:0] addr);
      ucode_type w;
      w = '0;
      unique case (addr)
         U_B_START: begin
            w.ops.clr_valid  = 1'b1;
            w.ops.init_build = 1'b1;
         end
         U_B_LOOP: begin
            w.cond   = COND_J_DONE;
            w.target = U_FIN;
            w.rsel   = RS_I;
         end
         U_B_RD1: begin
            w.rsel       = RS_I1;
            w.ops.save_a = 1'b1;
         end
         U_B_PAIR: begin
            w.ops.pair = 1'b1;
         end
         U_B_CHK: begin
            w.cond        = COND_K_ZERO;
            w.target      = U_B_LOOP;
            w.exec        = EX_TAKEN;
            w.ops.set_cur = 1'b1;
         end
         U_B_EMP: begin
            w.cond     = COND_NODE_EMPTY;
            w.target   = U_B_LOOP;
            w.exec     = EX_TAKEN;
            w.rsel     = RS_NODE;
            w.ops.fill = 1'b1;
         end
         U_B_CMP: begin
            w.cond      = COND_ALWAYS;
            w.target    = U_B_CHK;
            w.ops.climb = 1'b1;
         end
         U_R_CHK: begin
            w.cond        = COND_K_ZERO;
            w.target      = U_FIN;
            w.exec        = EX_TAKEN;
            w.ops.set_cur = 1'b1;
         end
         U_R_EMP: begin
            w.cond      = COND_NODE_EMPTY;
            w.target    = U_R_CHK;
            w.exec      = EX_TAKEN;
            w.rsel      = RS_NODE;
            w.ops.halve = 1'b1;
         end
         U_R_CMP: begin
            w.cond      = COND_ALWAYS;
            w.target    = U_R_CHK;
            w.ops.climb = 1'b1;
         end
         U_FIN: begin
            w.rsel = RS_CUR;
         end
         U_REPORT: begin
            w.cond       = COND_RSP_BUSY;
            w.target     = U_REPORT;
            w.exec       = EX_NOT_TAKEN;
            w.rsel       = RS_CUR;
            w.fin        = 1'b1;
            w.ops.report = 1'b1;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- design/loser_tree_merge_selector_top.sv -----
// Loser tree merge selector: microcoded sequencer with leaf key and loser node memories.
`timescale 1ns / 1ps

// A tree of losers that finds the smallest key among the leaves in use. A load request
// stores one leaf key and gives no result. A build request plays the whole tree; a replace
// request writes the previous winner's leaf and replays its path to the root. Both return
// the winning leaf and its key. A small microprogram steps a shared datapath in which the
// key memory has one registered read port, so a filled tree level takes a node read, a key
// read, and a compare and write in turn, and an empty one skips the compare. A replace of
// a leaf not in use writes no key and goes straight to the result. A build pairs the leaves
// after a setup step and carries each pair winner up through the filled nodes until it
// parks at an empty node or leaves the root, then reads out the result. A result that has
// not been taken yet holds the program in its last step, and the next request is accepted
// in the cycle after the result is loaded. The leaf count register is written through the
// csr channel while no request is in flight.
module loser_tree_merge_selector_top #(
   parameter int MAX_LEAVES = 16,
   parameter int KEY_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ltms_pkg::REQ_BITS-1:0]     req_type,
   input  logic [$clog2(MAX_LEAVES)-1:0]     req_leaf,
   input  logic [KEY_BITS-1:0]               req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [$clog2(MAX_LEAVES)-1:0]     rsp_winner_leaf,
   output logic [KEY_BITS-1:0]               rsp_winner_key,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ltms_pkg::CSR_BITS-1:0]     csr_leaves_in_use
);
   import ltms_pkg::*;

   localparam int LEAF_BITS = $clog2(MAX_LEAVES);
   localparam int CNT_BITS  = $clog2(MAX_LEAVES + 1);
   localparam int CMP_BITS  = (CNT_BITS > CSR_BITS) ? CNT_BITS : CSR_BITS;
   localparam logic [LEAF_BITS:0] MAX_IDX = (LEAF_BITS + 1)'(MAX_LEAVES);

   // Control state.
   logic                  busy_ff, busy_in;
   logic [UPC_BITS-1:0]   upc_ff, upc_in;
   logic [CSR_BITS-1:0]   csr_ff;
   logic [LEAF_BITS-1:0]  cur_win_ff, cur_win_in;
   logic [MAX_LEAVES-1:0] node_valid_ff, node_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [CNT_BITS-1:0]   i_ff, i_in;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic [LEAF_BITS-1:0]  k_ff, k_in;
   logic [LEAF_BITS-1:0]  win_leaf_ff, win_leaf_in;
   logic [KEY_BITS-1:0]   win_key_ff, win_key_in;
   logic [KEY_BITS-1:0]   save_key_ff, save_key_in;
   logic [LEAF_BITS-1:0]  rsp_leaf_ff, rsp_leaf_in;
   logic [KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;

   // Memories and their registered read data.
   logic [KEY_BITS-1:0]   key_mem [MAX_LEAVES];
   logic [LEAF_BITS-1:0]  node_mem [MAX_LEAVES];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [LEAF_BITS-1:0]  node_rd_ff;

   logic                  key_we;
   logic [LEAF_BITS-1:0]  key_waddr;
   logic [LEAF_BITS-1:0]  key_raddr;
   logic                  node_we;
   logic [LEAF_BITS-1:0]  node_waddr;
   logic [LEAF_BITS-1:0]  node_wdata;

   logic [CMP_BITS-1:0]   csr_ext;
   logic [CNT_BITS-1:0]   n;
   logic [CNT_BITS-1:0]   half_n;
   logic [CNT_BITS-1:0]   i_plus1;
   logic [CNT_BITS:0]     path_sum;
   logic                  req_xfer;
   logic                  leaf_in_tree;
   logic                  leaf_in_store;
   ucode_type             cw;
   logic                  take;
   logic                  ops_en;
   ops_type               op;
   logic                  a_gt;
   logic                  swap;

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign csr_ready = !busy_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_winner_leaf = rsp_leaf_ff;
   assign rsp_winner_key  = rsp_key_ff;

   // Leaf count in use, held to the range the tree supports.
   assign csr_ext = CMP_BITS'(csr_ff);
   always_comb begin
      if (csr_ext < CMP_BITS'(2)) begin
         n = CNT_BITS'(2);
      end else if (csr_ext > CMP_BITS'(MAX_LEAVES)) begin
         n = CNT_BITS'(MAX_LEAVES);
      end else begin
         n = CNT_BITS'(csr_ext);
      end
   end

   assign half_n        = n >> 1;
   assign i_plus1       = i_ff + CNT_BITS'(1);
   assign path_sum      = {1'b0, n} + (CNT_BITS + 1)'(req_leaf);
   assign leaf_in_tree  = CNT_BITS'(req_leaf) < n;
   assign leaf_in_store = {1'b0, req_leaf} < MAX_IDX;

   // Sequencer: fetch, condition test and operation gating.
   assign cw = rom_word(upc_ff);

   always_comb begin
      unique case (cw.cond)
         COND_NONE:       take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_J_DONE:     take = j_ff >= n;
         COND_K_ZERO:     take = k_ff == '0;
         COND_NODE_EMPTY: take = !node_valid_ff[k_ff];
         COND_RSP_BUSY:   take = rsp_valid_ff && !rsp_ready;
         default:         take = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cw.exec)
         EX_ALWAYS:    ops_en = 1'b1;
         EX_TAKEN:     ops_en = take;
         EX_NOT_TAKEN: ops_en = !take;
         default:      ops_en = 1'b0;
      endcase
   end

   assign op   = (busy_ff && ops_en) ? cw.ops : '0;
   assign a_gt = save_key_ff > key_rd_ff;
   assign swap = key_rd_ff < win_key_ff;

   always_comb begin
      unique case (cw.rsel)
         RS_I:    key_raddr = i_ff[LEAF_BITS-1:0];
         RS_I1:   key_raddr = i_plus1[LEAF_BITS-1:0];
         RS_NODE: key_raddr = node_rd_ff;
         RS_CUR:  key_raddr = cur_win_ff;
         default: key_raddr = cur_win_ff;
      endcase
   end

   // Key memory write port: loads and the new key of a replace.
   always_comb begin
      key_we    = 1'b0;
      key_waddr = req_leaf;
      if (req_xfer) begin
         if (req_type == REQ_LOAD) begin
            key_we = leaf_in_store;
         end else if (req_type == REQ_REPLACE) begin
            key_we = leaf_in_tree;
         end
      end
   end

   // Loser node write port. Only one node operation stands in any control word.
   always_comb begin
      node_we    = 1'b0;
      node_waddr = k_ff;
      node_wdata = win_leaf_ff;
      if (op.init_build) begin
         node_we    = n[0];
         node_waddr = half_n[LEAF_BITS-1:0];
         node_wdata = '0;
      end else if (op.pair) begin
         node_we    = 1'b1;
         node_waddr = j_ff[LEAF_BITS-1:0];
         node_wdata = a_gt ? i_ff[LEAF_BITS-1:0] : i_plus1[LEAF_BITS-1:0];
      end else if (op.fill) begin
         node_we = 1'b1;
      end else if (op.climb) begin
         node_we = swap;
      end
   end

   always_comb begin
      node_valid_in = op.clr_valid ? '0 : node_valid_ff;
      if (node_we) begin
         node_valid_in[node_waddr] = 1'b1;
      end
   end

   // Sequencer step and control registers.
   always_comb begin
      busy_in    = busy_ff;
      upc_in     = upc_ff;
      cur_win_in = op.set_cur ? win_leaf_ff : cur_win_ff;
      if (busy_ff) begin
         if (take) begin
            upc_in = cw.target;
         end else if (cw.fin) begin
            busy_in = 1'b0;
         end else begin
            upc_in = upc_ff + UPC_BITS'(1);
         end
      end else if (req_xfer) begin
         if (req_type == REQ_BUILD) begin
            busy_in = 1'b1;
            upc_in  = U_B_START;
         end else if (req_type == REQ_REPLACE) begin
            busy_in = 1'b1;
            upc_in  = leaf_in_tree ? U_R_CHK : U_FIN;
         end
      end
   end

   // Working registers of the datapath.
   always_comb begin
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      win_leaf_in = win_leaf_ff;
      win_key_in  = win_key_ff;
      save_key_in = op.save_a ? key_rd_ff : save_key_ff;
      if (req_xfer && req_type == REQ_REPLACE) begin
         win_leaf_in = req_leaf;
         win_key_in  = req_key;
         k_in        = path_sum[LEAF_BITS:1];
      end
      if (op.init_build) begin
         // With an odd leaf count, leaf 0 waits at node n/2 and pairing starts at leaf 1.
         i_in = CNT_BITS'(n[0]);
         j_in = half_n + CNT_BITS'(n[0]);
      end
      if (op.pair) begin
         win_leaf_in = a_gt ? i_plus1[LEAF_BITS-1:0] : i_ff[LEAF_BITS-1:0];
         win_key_in  = a_gt ? key_rd_ff : save_key_ff;
         k_in        = j_ff[LEAF_BITS:1];
         i_in        = i_ff + CNT_BITS'(2);
         j_in        = j_ff + CNT_BITS'(1);
      end
      if (op.climb) begin
         if (swap) begin
            win_leaf_in = node_rd_ff;
            win_key_in  = key_rd_ff;
         end
         k_in = k_ff >> 1;
      end
      if (op.halve) begin
         k_in = k_ff >> 1;
      end
   end

   // Result register: a new result may load in the cycle the held one is transferred.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_leaf_in  = rsp_leaf_ff;
      rsp_key_in   = rsp_key_ff;
      if (op.report) begin
         rsp_valid_in = 1'b1;
         rsp_leaf_in  = cur_win_ff;
         rsp_key_in   = key_rd_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         upc_ff        <= U_B_START;
         csr_ff        <= CSR_RESET;
         cur_win_ff    <= '0;
         node_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         upc_ff        <= upc_in;
         cur_win_ff    <= cur_win_in;
         node_valid_ff <= node_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_leaves_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      win_leaf_ff <= win_leaf_in;
      win_key_ff  <= win_key_in;
      save_key_ff <= save_key_in;
      rsp_leaf_ff <= rsp_leaf_in;
      rsp_key_ff  <= rsp_key_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= req_key;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rd_ff <= node_mem[k_ff];
   end

endmodule
